FILE: rtl/core/stack_arithmetic_unit_top_defines.svh
// Assertion macros used by the stack arithmetic unit checker.
// Included by bare file name; defines nothing but the macros below.
`ifndef STACK_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define STACK_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// Property checked only while reset is released.
`define SAU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Property checked on every edge, reset included.
`define SAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

FILE: rtl/core/sau_pkg.sv
// Package for the stack arithmetic unit: transaction types, opcodes, status codes.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package sau_pkg;

    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;
    localparam int DEPTH_W = 7;
    localparam int BIT_W   = $clog2(DATA_W);

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
    localparam logic [OP_W-1:0] OP_MOD  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
    localparam logic [ST_W-1:0] ST_ZDIV  = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
    } t_out_item;

endpackage

FILE: rtl/core/stack_arithmetic_unit_top.sv
// Stack arithmetic unit: 32-bit operand stack with a bit-serial arithmetic datapath.
// Depends on sau_pkg for the transaction types and codes.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries an opcode and a push
//   value. Output channel (o_out_valid / i_out_ready / o_out_item) returns exactly one
//   transaction per input: status, top of stack (zero when empty) and depth.
//   One operation is in flight at a time. A push, a full stack, an underflow or an
//   unused opcode goes from acceptance through the dispatch step to the output step,
//   which registers the result, and the unit is ready again after the output step.
//   A zero divisor is found in the read step and goes straight to the output step.
//   Add, sub, mul, div and mod read the second entry from the stack memory, then run
//   the serial datapath once per operand bit (one result bit per cycle for add and
//   sub, one multiplier bit for mul, one quotient bit for div and mod) and a fix-up
//   step that sets the sign for div and mod and writes the result back to the stack
//   before the output step.
//   A new operation may be accepted while a result still waits at the output; it is
//   held in its final step until the output register is free, so a stalled receiver
//   throttles the input but never loses a transaction.
//   Synchronous reset empties the stack and drops any pending result. Stack memory is
//   not cleared; only entries below the depth are ever used.
`timescale 1ns / 1ps

module stack_arithmetic_unit_top import sau_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_CALC = 3'd3;
    localparam logic [2:0] S_FIX  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rd;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_item, n_out_item;
    logic [OP_W-1:0]   r_op, n_op;
    logic [DATA_W-1:0] r_val, n_val;
    logic [DATA_W-1:0] r_tos, n_tos;
    logic [DATA_W-1:0] r_a, n_a;
    logic [DATA_W-1:0] r_b, n_b;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic              r_carry, n_carry;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic              r_neg_q, n_neg_q;
    logic              r_neg_r, n_neg_r;
    logic [ST_W-1:0]   r_status, n_status;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_wdata;

    logic [CW-1:0]     cnt_m1, cnt_m2;
    logic              w_bin, w_divop, w_out_free;
    logic              w_sum;
    logic [DATA_W+1:0] w_diff;
    logic [DATA_W-1:0] w_res;

    assign cnt_m1     = r_cnt - CW'(1);
    assign cnt_m2     = r_cnt - CW'(2);
    assign w_bin      = (r_op != OP_PUSH) && (r_op <= OP_MOD);
    assign w_divop    = (r_op == OP_DIV) || (r_op == OP_MOD);
    assign w_out_free = !r_out_valid || i_out_ready;

    // Serial full adder for add and sub.
    assign w_sum  = r_a[0] ^ r_b[0] ^ r_carry;
    // Restoring division trial subtract on the partial remainder.
    assign w_diff = {1'b0, r_acc, r_a[DATA_W-1]} - {2'b00, r_b};

    always_comb begin
        case (r_op)
            OP_DIV:  w_res = r_neg_q ? (~r_a + DATA_W'(1)) : r_a;
            OP_MOD:  w_res = r_neg_r ? (~r_acc + DATA_W'(1)) : r_acc;
            default: w_res = r_acc;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign mem_raddr   = cnt_m2[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        n_op        = r_op;
        n_val       = r_val;
        n_tos       = r_tos;
        n_a         = r_a;
        n_b         = r_b;
        n_acc       = r_acc;
        n_carry     = r_carry;
        n_bit       = r_bit;
        n_neg_q     = r_neg_q;
        n_neg_r     = r_neg_r;
        n_status    = r_status;
        mem_we      = 1'b0;
        mem_waddr   = r_cnt[AW-1:0];
        mem_wdata   = r_val;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in_item.op;
                    n_val   = i_in_item.push_value;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_status = ST_OK;
                n_state  = S_OUT;
                if (r_op == OP_PUSH) begin
                    if (r_cnt == CW'(STACK_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        mem_we = 1'b1;
                        n_tos  = r_val;
                        n_cnt  = r_cnt + CW'(1);
                    end
                end else if (w_bin) begin
                    if (r_cnt < CW'(2)) begin
                        n_status = ST_UNDER;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (w_divop && (r_tos == '0)) begin
                    n_status = ST_ZDIV;
                    n_state  = S_OUT;
                end else begin
                    n_bit   = '0;
                    n_acc   = '0;
                    n_a     = r_rd;
                    n_b     = r_tos;
                    n_carry = 1'b0;
                    n_state = S_CALC;
                    case (r_op)
                        OP_SUB: begin
                            n_b     = ~r_tos;
                            n_carry = 1'b1;
                        end
                        OP_DIV, OP_MOD: begin
                            n_a     = r_rd[DATA_W-1] ? (~r_rd + DATA_W'(1)) : r_rd;
                            n_b     = r_tos[DATA_W-1] ? (~r_tos + DATA_W'(1)) : r_tos;
                            n_neg_q = r_rd[DATA_W-1] ^ r_tos[DATA_W-1];
                            n_neg_r = r_rd[DATA_W-1];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CALC: begin
                case (r_op)
                    OP_ADD, OP_SUB: begin
                        n_acc   = {w_sum, r_acc[DATA_W-1:1]};
                        n_carry = (r_a[0] & r_b[0]) | (r_a[0] & r_carry) | (r_b[0] & r_carry);
                        n_a     = r_a >> 1;
                        n_b     = r_b >> 1;
                    end
                    OP_MUL: begin
                        n_acc = r_acc + (r_b[0] ? r_a : '0);
                        n_a   = r_a << 1;
                        n_b   = r_b >> 1;
                    end
                    default: begin
                        if (!w_diff[DATA_W+1]) begin
                            n_acc = w_diff[DATA_W-1:0];
                            n_a   = {r_a[DATA_W-2:0], 1'b1};
                        end else begin
                            n_acc = {r_acc[DATA_W-2:0], r_a[DATA_W-1]};
                            n_a   = {r_a[DATA_W-2:0], 1'b0};
                        end
                    end
                endcase
                n_bit = r_bit + BIT_W'(1);
                if (r_bit == BIT_W'(DATA_W - 1)) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_m2[AW-1:0];
                mem_wdata = w_res;
                n_tos     = w_res;
                n_cnt     = cnt_m1;
                n_status  = ST_OK;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid          = 1'b1;
                    n_out_item.status    = r_status;
                    n_out_item.top_value = (r_cnt != '0) ? r_tos : '0;
                    n_out_item.depth     = DEPTH_W'(r_cnt);
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        r_op       <= n_op;
        r_val      <= n_val;
        r_tos      <= n_tos;
        r_a        <= n_a;
        r_b        <= n_b;
        r_acc      <= n_acc;
        r_carry    <= n_carry;
        r_bit      <= n_bit;
        r_neg_q    <= n_neg_q;
        r_neg_r    <= n_neg_r;
        r_status   <= n_status;
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

endmodule

FILE: rtl/core/sau_checker.sv
// Port-level checker for the stack arithmetic unit, bound to the top level.
// Depends on sau_pkg and the assertion macros in stack_arithmetic_unit_top_defines.svh.
`timescale 1ns / 1ps
`include "stack_arithmetic_unit_top_defines.svh"

module sau_checker import sau_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // A reset always discards any pending result transaction.
    `SAU_ASSERT_ALWAYS(a_reset_drops_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // A stalled result must hold.
    `SAU_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item), "stalled result changed")

    // Only one operation is in flight: the input closes after each transaction.
    `SAU_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "input accepted twice in a row")

    // Full status only ever reports a stack at its capacity.
    `SAU_ASSERT(a_full_depth, i_clk, i_rst_n, o_out_valid && (o_out_item.status == ST_FULL) |-> o_out_item.depth == DEPTH_W'(STACK_DEPTH), "full status at wrong depth")

    // Underflow only ever reports fewer than two entries.
    `SAU_ASSERT(a_under_depth, i_clk, i_rst_n, o_out_valid && (o_out_item.status == ST_UNDER) |-> o_out_item.depth < DEPTH_W'(2), "underflow with two or more entries")

endmodule

bind stack_arithmetic_unit_top sau_checker #(.STACK_DEPTH(STACK_DEPTH)) u_sau_checker (.*);
